FILE: rtl/rtlpm_pkg.sv
// Package for the radix tree longest prefix match unit.
// Holds sizes, payload structs, status codes and the sequencer state type.
// No dependencies.
package rtlpm_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int KEY_WIDTH   = 32;
    localparam int ROUTE_WIDTH = 16;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int LEN_W       = $clog2(KEY_WIDTH + 1);
    localparam int USED_W      = $clog2(NODE_COUNT + 1);

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_LOOKUP = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_HIT      = 2'd1,
        ST_MISS     = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_func                  func;
        logic [KEY_WIDTH-1:0]   key_bits;
        logic [5:0]             key_len;
        logic [ROUTE_WIDTH-1:0] route_in;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [ROUTE_WIDTH-1:0] route_out;
    } t_out_item;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   label;
        logic [LEN_W-1:0]       label_len;
        logic [NODE_W-1:0]      child_zero;
        logic [NODE_W-1:0]      child_one;
        logic                   has_route;
        logic [ROUTE_WIDTH-1:0] route;
    } t_node;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_WAIT,
        S_CMP,
        S_SCAN,
        S_EVAL,
        S_SPLIT_CLONE,
        S_SPLIT_CUR,
        S_SPLIT_LEAF,
        S_LEAF,
        S_LEAF_LINK,
        S_DONE
    } t_state;

endpackage

FILE: rtl/radix_tree_longest_prefix_match_unit.sv
// Top level of the radix tree longest prefix match unit.
// Node memory, walk sequencer and one shared bit compare unit.
// Depends on rtlpm_pkg.
//
// Usage: drive i_in and pulse i_start while o_busy is low; the transaction is
// taken at that edge and o_busy rises on the next cycle. Insert (func 0)
// stores a prefix with a route; lookup (func 1) returns the route of the
// longest stored prefix matching the key. The result shows on o_out for one
// cycle with o_done high; the receiver cannot hold it off.
// Each visited node passes through the memory read (address, registered
// read data, compare setup), the bit-serial compare unit, which matches one
// label bit per cycle until a bit differs or the label or key ends, and an
// evaluate step. Adding a leaf then writes the leaf and links it into its
// parent; a split writes a clone of the node's tail, rewrites the node and,
// when the key goes on past the split point, writes a new leaf. The deepest
// walk visits 33 nodes on a 32-bit key. o_busy drops in the cycle of the
// strobe, so the next transaction can be taken at the edge that ends it.
// After reset the unit steps through every node address, writing only the
// root, with o_busy high; then it accepts transactions.
module radix_tree_longest_prefix_match_unit
    import rtlpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_in,
    output logic      o_busy,
    output logic      o_done,
    output t_out_item o_out
);

    t_node r_mem [NODE_COUNT];

    t_state r_state, n_state;
    logic [NODE_W-1:0]      r_addr, n_addr;
    t_node                  r_rd;
    t_node                  r_node, n_node;
    logic [NODE_W-1:0]      r_cur, n_cur;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [LEN_W-1:0]       r_klen, n_klen;
    logic [LEN_W-1:0]       r_pos, n_pos;
    logic [LEN_W-1:0]       r_cnt, n_cnt;
    logic [LEN_W-1:0]       r_lim, n_lim;
    logic [ROUTE_WIDTH-1:0] r_route, n_route;
    logic                   r_func, n_func;
    logic                   r_hit, n_hit;
    logic [ROUTE_WIDTH-1:0] r_found, n_found;
    logic [USED_W-1:0]      r_used, n_used;
    t_out_item              r_out, n_out;
    logic                   r_done, n_done;
    logic [NODE_W-1:0]      r_clone, n_clone;

    logic                   wr_en;
    logic [NODE_W-1:0]      wr_addr;
    t_node                  wr_data;

    logic [LEN_W-1:0]       rem;
    logic                   kbit, lbit, nbit, pbit;
    logic [KEY_WIDTH-1:0]   key_sh, lab_sh, lab_head, pos_sh;
    logic [LEN_W-1:0]       klen_sat;
    logic [KEY_WIDTH-1:0]   kmask;
    logic [USED_W-1:0]      need;

    // left-aligned mask of n bits
    function automatic logic [KEY_WIDTH-1:0] lmask(input logic [LEN_W-1:0] n);
        logic [KEY_WIDTH-1:0] m;
        m = '1;
        if (n >= LEN_W'(KEY_WIDTH)) lmask = m;
        else if (n == '0) lmask = '0;
        else lmask = ~(m >> n);
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[r_addr];
    end

    always_comb begin
        klen_sat = (i_in.key_len > 6'(KEY_WIDTH)) ? LEN_W'(KEY_WIDTH)
                                                   : LEN_W'(i_in.key_len);
        kmask    = lmask(klen_sat);
        rem      = r_klen - r_pos;
        // shared compare unit: one label bit against one key bit
        key_sh   = r_key << (r_pos + r_cnt);
        lab_sh   = r_node.label << r_cnt;
        kbit     = key_sh[KEY_WIDTH-1];
        lbit     = lab_sh[KEY_WIDTH-1];
        nbit     = (r_pos + r_node.label_len < LEN_W'(KEY_WIDTH))
                   ? key_sh[KEY_WIDTH-1] : 1'b0;
        // key bit at the current position, picks the side of a new leaf
        pos_sh   = r_key << r_pos;
        pbit     = (r_pos < LEN_W'(KEY_WIDTH)) ? pos_sh[KEY_WIDTH-1] : 1'b0;
        lab_head = r_node.label & lmask(r_cnt);
        need     = (r_cnt == rem) ? USED_W'(1) : USED_W'(2);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_READ;
            S_CLEAR: if (r_addr == NODE_W'(NODE_COUNT - 1)) n_state = S_IDLE;
            S_READ:  n_state = S_WAIT;
            S_WAIT:  n_state = S_CMP;
            S_CMP:   n_state = S_SCAN;
            S_SCAN:  if (r_cnt == r_lim || kbit != lbit) n_state = S_EVAL;
            S_EVAL:  n_state = S_DONE;
            S_SPLIT_CLONE: n_state = S_SPLIT_CUR;
            S_SPLIT_CUR:   n_state = (r_cnt == rem) ? S_DONE : S_SPLIT_LEAF;
            S_SPLIT_LEAF:  n_state = S_DONE;
            S_LEAF:        n_state = S_LEAF_LINK;
            S_LEAF_LINK:   n_state = S_DONE;
            S_DONE:        n_state = S_IDLE;
            default:       n_state = S_IDLE;
        endcase
        if (r_state == S_EVAL) begin
            if (r_func == FUNC_LOOKUP) begin
                if (r_node.label_len <= rem && r_cnt == r_node.label_len &&
                    r_pos + r_node.label_len < r_klen) begin
                    if ((nbit ? r_node.child_one : r_node.child_zero) != '0)
                        n_state = S_READ;
                end
            end else if (r_cnt == r_node.label_len) begin
                if (r_cnt != rem) begin
                    if ((nbit ? r_node.child_one : r_node.child_zero) != '0)
                        n_state = S_READ;
                    else if (r_used + USED_W'(1) <= USED_W'(NODE_COUNT))
                        n_state = S_LEAF;
                end
            end else if (r_used + need <= USED_W'(NODE_COUNT)) begin
                n_state = S_SPLIT_CLONE;
            end
        end
    end

    // datapath and outputs
    always_comb begin
        n_addr  = r_addr;
        n_node  = r_node;
        n_cur   = r_cur;
        n_key   = r_key;
        n_klen  = r_klen;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_lim   = r_lim;
        n_route = r_route;
        n_func  = r_func;
        n_hit   = r_hit;
        n_found = r_found;
        n_used  = r_used;
        n_out   = r_out;
        n_done  = 1'b0;
        n_clone = r_clone;
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func  = i_in.func;
                    n_key   = i_in.key_bits & kmask;
                    n_klen  = klen_sat;
                    n_route = i_in.route_in;
                    n_pos   = '0;
                    n_cur   = '0;
                    n_addr  = '0;
                    n_hit   = 1'b0;
                    n_found = '0;
                end
            end
            S_CLEAR: begin
                // only the root matters; others are written on allocation
                wr_en   = (r_addr == '0);
                wr_addr = r_addr;
                n_addr  = r_addr + NODE_W'(1);
            end
            S_CMP: begin
                n_node = r_rd;
                n_cnt  = '0;
                n_lim  = (r_rd.label_len < rem) ? r_rd.label_len : rem;
            end
            S_SCAN: begin
                if (r_cnt != r_lim && kbit == lbit) n_cnt = r_cnt + LEN_W'(1);
            end
            S_EVAL: begin
                n_out.route_out = '0;
                if (r_func == FUNC_LOOKUP) begin
                    n_out.status = r_hit ? ST_HIT : ST_MISS;
                    n_out.route_out = r_hit ? r_found : '0;
                    if (r_node.label_len <= rem && r_cnt == r_node.label_len) begin
                        if (r_node.has_route) begin
                            n_out.status    = ST_HIT;
                            n_out.route_out = r_node.route;
                            n_hit   = 1'b1;
                            n_found = r_node.route;
                        end
                        n_pos  = r_pos + r_node.label_len;
                        n_cur  = nbit ? r_node.child_one : r_node.child_zero;
                        n_addr = n_cur;
                    end
                end else begin
                    n_out.status = ST_INSERTED;
                    if (r_cnt == r_node.label_len) begin
                        if (r_cnt == rem) begin
                            wr_en = 1'b1;
                            wr_addr = r_cur;
                            wr_data = r_node;
                            wr_data.has_route = 1'b1;
                            wr_data.route = r_route;
                        end else begin
                            n_pos  = r_pos + r_node.label_len;
                            n_cur  = nbit ? r_node.child_one : r_node.child_zero;
                            n_addr = n_cur;
                            if (n_cur == '0 && r_used + USED_W'(1) > USED_W'(NODE_COUNT))
                                n_out.status = ST_FULL;
                            if (n_cur == '0) n_cur = r_cur;
                        end
                    end else if (r_used + need > USED_W'(NODE_COUNT)) begin
                        n_out.status = ST_FULL;
                    end
                end
            end
            S_SPLIT_CLONE: begin
                n_clone = NODE_W'(r_used);
                wr_en   = 1'b1;
                wr_addr = NODE_W'(r_used);
                wr_data = r_node;
                wr_data.label = r_node.label << r_cnt;
                wr_data.label_len = r_node.label_len - r_cnt;
                n_used  = r_used + USED_W'(1);
            end
            S_SPLIT_CUR: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = '0;
                wr_data.label = lab_head;
                wr_data.label_len = r_cnt;
                if (lbit) wr_data.child_one = r_clone;
                else wr_data.child_zero = r_clone;
                if (r_cnt == rem) begin
                    wr_data.has_route = 1'b1;
                    wr_data.route = r_route;
                end else begin
                    // key bit differs from label bit here
                    if (kbit) wr_data.child_one = NODE_W'(r_used);
                    else wr_data.child_zero = NODE_W'(r_used);
                end
            end
            S_SPLIT_LEAF: begin
                wr_en   = 1'b1;
                wr_addr = NODE_W'(r_used);
                wr_data = '0;
                wr_data.label = r_key << (r_pos + r_cnt);
                wr_data.label_len = rem - r_cnt;
                wr_data.has_route = 1'b1;
                wr_data.route = r_route;
                n_used  = r_used + USED_W'(1);
            end
            S_LEAF: begin
                // r_pos already advanced past the node label
                wr_en   = 1'b1;
                wr_addr = NODE_W'(r_used);
                wr_data = '0;
                wr_data.label = r_key << r_pos;
                wr_data.label_len = rem;
                wr_data.has_route = 1'b1;
                wr_data.route = r_route;
                n_clone = NODE_W'(r_used);
                n_used  = r_used + USED_W'(1);
            end
            S_LEAF_LINK: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = r_node;
                if (pbit)
                    wr_data.child_one = r_clone;
                else
                    wr_data.child_zero = r_clone;
            end
            S_DONE: begin
                n_done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_used  <= USED_W'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_used  <= n_used;
            r_done  <= n_done;
        end
        r_node  <= n_node;
        r_cur   <= n_cur;
        r_key   <= n_key;
        r_klen  <= n_klen;
        r_pos   <= n_pos;
        r_cnt   <= n_cnt;
        r_lim   <= n_lim;
        r_route <= n_route;
        r_func  <= n_func;
        r_hit   <= n_hit;
        r_found <= n_found;
        r_out   <= n_out;
        r_clone <= n_clone;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

FILE: tb/testbench.sv
// Testbench for the radix tree longest prefix match unit.
// Drives insert and lookup transactions, predicts each result with a tree model
// of its own and checks o_out when o_done is high. Depends on rtlpm_pkg and the RTL.
`timescale 1ns / 100ps

module testbench
    import rtlpm_pkg::*;
();

    localparam int CYCLE_LIMIT = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_in;
    logic      o_busy;
    logic      o_done;
    t_out_item o_out;

    radix_tree_longest_prefix_match_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // tree copy kept by the predictor
    logic [31:0] tr_label [NODE_COUNT];
    int          tr_len   [NODE_COUNT];
    int          tr_zero  [NODE_COUNT];
    int          tr_one   [NODE_COUNT];
    bit          tr_has   [NODE_COUNT];
    logic [15:0] tr_route [NODE_COUNT];
    int          tr_used;

    t_out_item   pending_results [$];
    logic [31:0] stored_prefix [$];
    int          stored_plen [$];
    int          mismatches;
    int          cycles;
    int          gap_pct;
    int          full_seen;

    function automatic bit bit_of(logic [31:0] v, int i);
        if (i >= 32) return 1'b0;
        return v[31-i];
    endfunction

    function automatic logic [31:0] bits_from(logic [31:0] v, int first, int n);
        if (first >= 32 || n == 0) return 32'h0;
        v = v << first;
        if (n >= 32) return v;
        return v & ~(32'hFFFF_FFFF >> n);
    endfunction

    function automatic int shared_bits(int nd, logic [31:0] key, int pos, int rem);
        int lim;
        int i;
        lim = (rem < tr_len[nd]) ? rem : tr_len[nd];
        i = 0;
        while (i < lim && bit_of(tr_label[nd], i) == bit_of(key, pos + i)) i++;
        return i;
    endfunction

    function automatic int alloc_node(logic [31:0] lab, int len, logic [15:0] route);
        int n;
        n = tr_used;
        tr_used++;
        tr_label[n] = lab;
        tr_len[n]   = len;
        tr_zero[n]  = 0;
        tr_one[n]   = 0;
        tr_has[n]   = 1'b1;
        tr_route[n] = route;
        return n;
    endfunction

    function automatic void link(int nd, bit b, int c);
        if (b) tr_one[nd] = c;
        else tr_zero[nd] = c;
    endfunction

    function automatic t_status tree_insert(logic [31:0] key, int klen, logic [15:0] route);
        int cur;
        int pos;
        int len;
        int rem;
        int c;
        int nx;
        int cl;
        int lf;
        logic [31:0] lab;
        cur = 0;
        pos = 0;
        forever begin
            len = tr_len[cur];
            rem = klen - pos;
            c = shared_bits(cur, key, pos, rem);
            if (c == len && c == rem) begin
                tr_has[cur] = 1'b1;
                tr_route[cur] = route;
                return ST_INSERTED;
            end
            if (c == len) begin
                pos += len;
                nx = bit_of(key, pos) ? tr_one[cur] : tr_zero[cur];
                if (nx == 0) begin
                    if (tr_used + 1 > NODE_COUNT) return ST_FULL;
                    lf = alloc_node(bits_from(key, pos, klen - pos), klen - pos, route);
                    link(cur, bit_of(key, pos), lf);
                    return ST_INSERTED;
                end
                cur = nx;
            end else begin
                if (tr_used + ((c == rem) ? 1 : 2) > NODE_COUNT) return ST_FULL;
                lab = tr_label[cur];
                // clone takes the old remainder with its children and route
                cl = alloc_node(bits_from(lab, c, len - c), len - c, tr_route[cur]);
                tr_has[cl]  = tr_has[cur];
                tr_zero[cl] = tr_zero[cur];
                tr_one[cl]  = tr_one[cur];
                tr_label[cur] = bits_from(lab, 0, c);
                tr_len[cur]   = c;
                tr_zero[cur]  = 0;
                tr_one[cur]   = 0;
                tr_has[cur]   = 1'b0;
                tr_route[cur] = 16'h0;
                link(cur, bit_of(lab, c), cl);
                if (c == rem) begin
                    tr_has[cur] = 1'b1;
                    tr_route[cur] = route;
                end else begin
                    lf = alloc_node(bits_from(key, pos + c, klen - pos - c),
                                    klen - pos - c, route);
                    link(cur, bit_of(key, pos + c), lf);
                end
                return ST_INSERTED;
            end
        end
    endfunction

    function automatic t_out_item tree_lookup(logic [31:0] key, int klen);
        t_out_item r;
        int cur;
        int pos;
        cur = 0;
        pos = 0;
        r.status = ST_MISS;
        r.route_out = '0;
        forever begin
            if (tr_len[cur] > klen - pos) break;
            if (shared_bits(cur, key, pos, klen - pos) < tr_len[cur]) break;
            pos += tr_len[cur];
            if (tr_has[cur]) begin
                r.status = ST_HIT;
                r.route_out = tr_route[cur];
            end
            if (pos >= klen) break;
            cur = bit_of(key, pos) ? tr_one[cur] : tr_zero[cur];
            if (cur == 0) break;
        end
        return r;
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        int klen;
        logic [31:0] key;
        klen = (it.key_len > 32) ? 32 : int'(it.key_len);
        key = bits_from(it.key_bits, 0, klen);
        if (it.func == FUNC_INSERT) begin
            r.status = tree_insert(key, klen, it.route_in);
            r.route_out = '0;
            if (r.status == ST_FULL) full_seen++;
            else begin
                stored_prefix.push_back(key);
                stored_plen.push_back(klen);
            end
        end else begin
            r = tree_lookup(key, klen);
        end
        return r;
    endfunction

    // start stays high when the next transaction follows without a gap
    task automatic send_item(t_func f, logic [31:0] bits, logic [5:0] len, logic [15:0] route);
        t_in_item it;
        it.func = f;
        it.key_bits = bits;
        it.key_len = len;
        it.route_in = route;
        i_in <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(predict_result(it));
        if ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int ins_pct);
        logic [31:0] bits;
        int len;
        int k;
        bits = $urandom();
        len = ($urandom_range(9) == 0) ? $urandom_range(33, 63) : $urandom_range(32);
        if ($urandom_range(99) < ins_pct) begin
            // narrow prefixes under a few top bits keep the tree deep
            if ($urandom_range(1)) bits[31:28] = 4'hA;
            send_item(FUNC_INSERT, bits, len[5:0], 16'($urandom()));
        end else begin
            if (stored_prefix.size() > 0 && $urandom_range(3) != 0) begin
                k = $urandom_range(stored_prefix.size() - 1);
                bits = stored_prefix[k] | bits_from(bits, stored_plen[k], 32);
                len = $urandom_range(stored_plen[k], 32);
                if ($urandom_range(3) == 0) len = $urandom_range(32);
            end
            send_item(FUNC_LOOKUP, bits, len[5:0], 16'($urandom()));
        end
    endtask

    task automatic test_directed();
        gap_pct = 29;
        send_item(FUNC_LOOKUP, 32'h0, 6'd0, 16'h1234);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'h0);
        send_item(FUNC_INSERT, 32'hDEAD_BEEF, 6'd0, 16'hFFFF);     // default route
        send_item(FUNC_LOOKUP, 32'h1234_5678, 6'd17, 16'h0);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h0000);
        send_item(FUNC_INSERT, 32'h0000_0000, 6'd32, 16'h5A5A);
        send_item(FUNC_INSERT, 32'hA5A5_A5A5, 6'd63, 16'h00F0);    // saturated length
        send_item(FUNC_LOOKUP, 32'hA5A5_A5A5, 6'd33, 16'h0);
        send_item(FUNC_INSERT, 32'hAFFF_FFFF, 6'd4, 16'h0101);     // low bits ignored
        send_item(FUNC_LOOKUP, 32'hA000_0000, 6'd4, 16'h0);
        send_item(FUNC_INSERT, 32'hA000_0000, 6'd4, 16'h0202);     // re-insertion
        send_item(FUNC_INSERT, 32'h8000_0000, 6'd2, 16'h0303);     // split at prefix end
        send_item(FUNC_INSERT, 32'hB000_0000, 6'd4, 16'h0404);     // split plus new leaf
        send_item(FUNC_LOOKUP, 32'hB123_4567, 6'd32, 16'h0);
        send_item(FUNC_LOOKUP, 32'h9000_0000, 6'd4, 16'h0);
        send_item(FUNC_LOOKUP, 32'hA000_0000, 6'd3, 16'h0);        // ends on a node without a route
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFE, 6'd32, 16'h0);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'h0);
        send_item(FUNC_LOOKUP, 32'h0000_0001, 6'd31, 16'h0);
        send_item(FUNC_LOOKUP, 32'h5555_5555, 6'd48, 16'hAAAA);
    endtask

    task automatic test_random_mix();
        gap_pct = 29;
        repeat (500) send_random(45);
        gap_pct = 81;
        repeat (500) send_random(45);
        gap_pct = 0;
        repeat (500) send_random(45);
    endtask

    task automatic test_pool_full();
        int n;
        gap_pct = 10;
        n = 0;
        while (full_seen < 8 && n < 1500) begin
            send_item(FUNC_INSERT, $urandom(), 6'($urandom_range(20, 32)), 16'($urandom()));
            n++;
        end
        repeat (60) send_random(30);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d route %h", o_out.status,
                             o_out.route_out);
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status || o_out.route_out !== want.route_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d route %h,",
                                 want.status, want.route_out,
                                 " got status %0d route %h",
                                 o_out.status, o_out.route_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        cycles = 0;
        full_seen = 0;
        gap_pct = 0;
        tr_used = 1;
        tr_label[0] = '0;
        tr_len[0] = 0;
        tr_zero[0] = 0;
        tr_one[0] = 0;
        tr_has[0] = 1'b0;
        tr_route[0] = '0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_mix();
        test_pool_full();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
